// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    // Operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_RECV  = 2'd0,
        OP_IDLE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_DISCARD    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_BYTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_END      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESC      = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] idle_timeout;
        logic [LEN_W-1:0]  capacity;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] esc_byte;
        logic [BYTE_W-1:0] esc_end;
        logic [BYTE_W-1:0] esc_esc;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

endpackage

// ===== rtl/sfr_if.sv =====
`timescale 1ns / 1ps

interface sfr_in_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] data_byte;
    logic [TIME_W-1:0] now_ms;
    logic [ADDR_W-1:0] read_index;

    modport source (output valid, operation, data_byte, now_ms, read_index, input ready);
    modport sink   (input valid, operation, data_byte, now_ms, read_index, output ready);
endinterface

interface sfr_out_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, status, frame_length, read_data, input ready);
    modport sink   (input valid, status, frame_length, read_data, output ready);
endinterface

// ===== rtl/slip_frame_receiver.sv =====
`timescale 1ns / 1ps

// A result is presented in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the result register is empty or
//   being drained; the state update and the payload memory read are registered.
// Reset (synchronous, active low): frame state cleared, config to SLIP defaults,
//   result register emptied; payload memory is not cleared.
module slip_frame_receiver
    import sfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfr_in_if.sink                i_in,
    sfr_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              r_cfg;
    t_op               in_op;
    logic              in_accept;
    logic [1:0]        ctrl_status;
    logic [LEN_W-1:0]  ctrl_len;
    t_wr_req           wr_req;
    logic              rd_en;
    logic [BYTE_W-1:0] mem_rdata;

    // Result register
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [LEN_W-1:0]  r_len;
    logic              r_is_read;

    // ---------------------------------------------------------------
    // Configuration registers; unknown indexes are dropped.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout <= '0;
            r_cfg.capacity     <= MAX_LEN;
            r_cfg.end_byte     <= 8'd192;
            r_cfg.esc_byte     <= 8'd219;
            r_cfg.esc_end      <= 8'd220;
            r_cfg.esc_esc      <= 8'd221;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_cfg_data[TIME_W-1:0];
                CFG_CAPACITY:     r_cfg.capacity     <= i_cfg_data[LEN_W-1:0];
                CFG_END_BYTE:     r_cfg.end_byte     <= i_cfg_data[BYTE_W-1:0];
                CFG_ESC_BYTE:     r_cfg.esc_byte     <= i_cfg_data[BYTE_W-1:0];
                CFG_ESC_END:      r_cfg.esc_end      <= i_cfg_data[BYTE_W-1:0];
                CFG_ESC_ESC:      r_cfg.esc_esc      <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input side: a new transaction is taken whenever the result register
    // is empty or is being drained in the same cycle.
    // ---------------------------------------------------------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;
    assign in_op      = t_op'(i_in.operation);

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (in_accept),
        .i_op       (in_op),
        .i_byte     (i_in.data_byte),
        .i_now      (i_in.now_ms),
        .o_status   (ctrl_status),
        .o_len_next (ctrl_len),
        .o_wr       (wr_req)
    );

    // Payload bytes are written at the accepting edge, so a read taken in the
    // very next cycle already sees them; no forwarding path is needed.
    assign rd_en = in_accept && (in_op == OP_READ);

    sfr_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr_req),
        .i_re    (rd_en),
        .i_raddr (i_in.read_index),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Result register. The memory read data register only moves on an
    // accepted read, so it holds with the rest of the result under stall.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status  <= ctrl_status;
            r_len     <= ctrl_len;
            r_is_read <= (in_op == OP_READ);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.frame_length = r_len;
    assign o_out.read_data    = r_is_read ? mem_rdata : '0;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_op == OP_CLEAR |=>
            o_out.valid && o_out.status == ST_INCOMPLETE && o_out.frame_length == '0)
        else $error("clear transaction did not give an empty incomplete result");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.frame_length <= MAX_LEN)
        else $error("frame length beyond payload capacity");

    a_write_on_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.we |-> in_accept && in_op == OP_RECV)
        else $error("payload write outside an accepted receive transaction");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.we |=> o_out.frame_length == LEN_W'($past(wr_req.addr)) + 1'b1)
        else $error("stored byte did not extend the frame by one");

endmodule

// ===== rtl/sfr_store.sv =====
`timescale 1ns / 1ps

// Payload memory: one write port, one registered read port.
module sfr_store
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sfr_ctrl.sv =====
`timescale 1ns / 1ps

// Deframer state: length, escape and discard flags, last byte time.
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  t_op               i_op,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [TIME_W-1:0] i_now,
    output logic [1:0]        o_status,
    output logic [LEN_W-1:0]  o_len_next,
    output t_wr_req           o_wr
);

    logic [LEN_W-1:0]  r_len,  n_len;
    logic              r_esc,  n_esc;
    logic              r_disc, n_disc;
    logic [TIME_W-1:0] r_last, n_last;

    logic [LEN_W-1:0]  cap_now;
    logic              do_store;
    logic [BYTE_W-1:0] store_val;
    logic              do_clear;
    logic              do_discard;
    logic [TIME_W-1:0] idle_gap;

    assign cap_now  = (i_cfg.capacity > MAX_LEN) ? MAX_LEN : i_cfg.capacity;
    assign idle_gap = i_now - r_last;

    always_comb begin
        o_status   = ST_INCOMPLETE;
        do_store   = 1'b0;
        store_val  = i_byte;
        do_clear   = 1'b0;
        do_discard = 1'b0;
        n_esc      = r_esc;
        n_last     = r_last;
        case (i_op)
            OP_RECV: begin
                n_last = i_now;
                if (r_disc) begin
                    if (i_byte == i_cfg.end_byte) begin
                        do_clear = 1'b1;
                        o_status = ST_DISCARD;
                    end
                end else if (r_esc) begin
                    n_esc = 1'b0;
                    if (i_byte == i_cfg.esc_end) begin
                        do_store  = 1'b1;
                        store_val = i_cfg.end_byte;
                    end else if (i_byte == i_cfg.esc_esc) begin
                        do_store  = 1'b1;
                        store_val = i_cfg.esc_byte;
                    end else if (i_byte == i_cfg.end_byte) begin
                        do_clear = 1'b1;
                        o_status = ST_DISCARD;
                    end else begin
                        do_discard = 1'b1;
                    end
                end else if (i_byte == i_cfg.end_byte) begin
                    o_status = (r_len == '0) ? ST_INCOMPLETE : ST_COMPLETE;
                end else if (i_byte == i_cfg.esc_byte) begin
                    n_esc = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end
            OP_IDLE: begin
                if (i_cfg.idle_timeout != '0 && (r_disc || r_esc || r_len != '0)
                        && idle_gap >= i_cfg.idle_timeout) begin
                    do_clear = 1'b1;
                end
            end
            OP_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
                // payload read leaves the state alone
            end
        endcase

        // overflow check against the capacity in use
        if (do_store && r_len >= cap_now) begin
            do_store   = 1'b0;
            do_discard = 1'b1;
        end

        n_len  = do_store ? r_len + 1'b1 : r_len;
        n_disc = r_disc;
        if (do_discard) begin
            n_len  = '0;
            n_esc  = 1'b0;
            n_disc = 1'b1;
        end
        if (do_clear) begin
            n_len  = '0;
            n_esc  = 1'b0;
            n_disc = 1'b0;
            n_last = '0;
        end
    end

    assign o_len_next = n_len;
    assign o_wr.we    = i_accept && do_store;
    assign o_wr.addr  = r_len[ADDR_W-1:0];
    assign o_wr.data  = store_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_esc  <= 1'b0;
            r_disc <= 1'b0;
            r_last <= '0;
        end else if (i_accept) begin
            r_len  <= n_len;
            r_esc  <= n_esc;
            r_disc <= n_disc;
            r_last <= n_last;
        end
    end

endmodule

// ===== tb/sfr_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// receiver state and checks every result transaction in order.
module sfr_result_checker
    import sfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfr_in_if                     i_in_mon,
    sfr_out_if                    i_out_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_awaiting,
    output int                    o_fail_count
);

    typedef struct packed {
        logic [1:0]        status;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] read_data;
    } t_report;

    t_cfg              cfg;
    logic [LEN_W-1:0]  held_len;
    logic              esc_seen;
    logic              dropping;
    logic [TIME_W-1:0] last_rx_ms;
    logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
    t_report           awaited_reports [$];
    t_report           got;
    t_report           want;
    int                mismatches;

    function automatic void reset_frame();
        held_len   = '0;
        esc_seen   = 1'b0;
        dropping   = 1'b0;
        last_rx_ms = '0;
    endfunction

    function automatic void start_drop();
        held_len = '0;
        esc_seen = 1'b0;
        dropping = 1'b1;
    endfunction

    // capacity register saturates at the store size
    function automatic void push_byte(logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] room;
        room = (cfg.capacity > MAX_LEN) ? MAX_LEN : cfg.capacity;
        if (held_len >= room) begin
            start_drop();
        end else begin
            payload_mem[held_len[ADDR_W-1:0]] = b;
            held_len++;
        end
    endfunction

    function automatic t_report deframe_step(t_op op, logic [BYTE_W-1:0] b,
                                             logic [TIME_W-1:0] now,
                                             logic [ADDR_W-1:0] idx);
        t_report           rep;
        logic [TIME_W-1:0] gap;
        rep = '0;
        case (op)
            OP_RECV: begin
                last_rx_ms = now;
                if (dropping) begin
                    if (b == cfg.end_byte) begin
                        reset_frame();
                        rep.status = ST_DISCARD;
                    end
                end else if (esc_seen) begin
                    esc_seen = 1'b0;
                    if (b == cfg.esc_end) begin
                        push_byte(cfg.end_byte);
                    end else if (b == cfg.esc_esc) begin
                        push_byte(cfg.esc_byte);
                    end else if (b == cfg.end_byte) begin
                        reset_frame();
                        rep.status = ST_DISCARD;
                    end else begin
                        start_drop();
                    end
                end else if (b == cfg.end_byte) begin
                    if (held_len != '0) rep.status = ST_COMPLETE;
                end else if (b == cfg.esc_byte) begin
                    esc_seen = 1'b1;
                end else begin
                    push_byte(b);
                end
            end
            OP_IDLE: begin
                gap = now - last_rx_ms;     // wraps at 32 bits
                if (cfg.idle_timeout != '0 && (dropping || esc_seen || held_len != '0)
                        && gap >= cfg.idle_timeout)
                    reset_frame();
            end
            OP_READ: rep.read_data = payload_mem[idx];
            default: reset_frame();
        endcase
        rep.frame_length = held_len;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.idle_timeout = '0;
            cfg.capacity     = MAX_LEN;
            cfg.end_byte     = 8'hC0;
            cfg.esc_byte     = 8'hDB;
            cfg.esc_end      = 8'hDC;
            cfg.esc_esc      = 8'hDD;
            reset_frame();
            awaited_reports.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDLE_TIMEOUT: cfg.idle_timeout = i_cfg_data;
                    CFG_CAPACITY:     cfg.capacity     = i_cfg_data[LEN_W-1:0];
                    CFG_END_BYTE:     cfg.end_byte     = i_cfg_data[BYTE_W-1:0];
                    CFG_ESC_BYTE:     cfg.esc_byte     = i_cfg_data[BYTE_W-1:0];
                    CFG_ESC_END:      cfg.esc_end      = i_cfg_data[BYTE_W-1:0];
                    CFG_ESC_ESC:      cfg.esc_esc      = i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            // results first: a transaction accepted at this edge cannot answer yet
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.status       = i_out_mon.status;
                got.frame_length = i_out_mon.frame_length;
                got.read_data    = i_out_mon.read_data;
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected result, actual status %0d length %0d data %0h",
                             $time, got.status, got.frame_length, got.read_data);
                    mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.frame_length !== want.frame_length) begin
                        $display("%0t: frame_length expected %0d, actual %0d",
                                 $time, want.frame_length, got.frame_length);
                        mismatches++;
                    end
                    if (got.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %0h, actual %0h",
                                 $time, want.read_data, got.read_data);
                        mismatches++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                awaited_reports.push_back(deframe_step(t_op'(i_in_mon.operation),
                                                       i_in_mon.data_byte, i_in_mon.now_ms,
                                                       i_in_mon.read_index));
        end
        o_awaiting   <= awaited_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Frame receiver bench. The top only drives traffic and gives the verdict;
// all prediction and comparison sits in sfr_result_checker.
//
// Run order:
//   - reset, SLIP default registers
//   - one full-capacity frame that writes every payload entry, so any later
//     read is of a written entry, then one byte over capacity and the END
//     that reports the discard
//   - a short hand-made sequence around the special cases
//   - eight random phases, each with its own register setting and gap mode
module tb;
    import sfr_pkg::*;

    localparam int HOLDOFF_CYCLES = 400;

    // register indexes with no register behind them: writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        GAPS_NONE,
        GAPS_SENDER,
        GAPS_RECEIVER,
        GAPS_BOTH
    } t_gap_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    awaiting;
    int                    fail_count;
    int                    send_idle_pct;
    int                    stall_pct;
    int                    holdoff_requests;
    int                    holdoff_served;
    int                    sent;
    t_cfg                  cur;         // register values last written
    logic [TIME_W-1:0]     tick_ms;     // running millisecond count for traffic

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();

    slip_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    sfr_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_awaiting   (awaiting),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side. Random stalls, plus a long hold-off on request so the
    // output register fills and the input stalls behind it.
    initial begin
        holdoff_served = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_served < holdoff_requests) begin
                out_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_served++;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // One input transaction: optional gap cycles, then hold valid until taken.
    task automatic send(t_op op, logic [BYTE_W-1:0] b, logic [TIME_W-1:0] now,
                        logic [ADDR_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.data_byte  <= b;
        in_ch.now_ms     <= now;
        in_ch.read_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    // received byte zero to three ms ticks after the previous one
    task automatic rx(logic [BYTE_W-1:0] b);
        tick_ms += $urandom_range(0, 3);
        send(OP_RECV, b, tick_ms, ADDR_W'($urandom()));
    endtask

    // payload byte with byte stuffing under the current delimiter codes
    task automatic rx_literal(logic [BYTE_W-1:0] v);
        if (v == cur.end_byte) begin
            rx(cur.esc_byte);
            rx(cur.esc_end);
        end else if (v == cur.esc_byte) begin
            rx(cur.esc_byte);
            rx(cur.esc_esc);
        end else begin
            rx(v);
        end
    endtask

    // Idle check: a random jump, one at or just either side of the timeout boundary, or a
    // random absolute time (exercises wrap-around of the gap)
    task automatic idle_probe();
        case ($urandom_range(0, 3))
            0: tick_ms = $urandom();
            1: tick_ms += cur.idle_timeout - 1 + $urandom_range(0, 2);
            default: tick_ms += $urandom_range(0, 3000);
        endcase
        send(OP_IDLE, BYTE_W'($urandom()), tick_ms, ADDR_W'($urandom()));
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // only called with the receiver idle
    task automatic load_cfg(t_cfg c);
        reg_write(CFG_IDLE_TIMEOUT, c.idle_timeout);
        reg_write(CFG_CAPACITY,     CFG_DATA_W'(c.capacity));
        reg_write(CFG_END_BYTE,     CFG_DATA_W'(c.end_byte));
        reg_write(CFG_ESC_BYTE,     CFG_DATA_W'(c.esc_byte));
        reg_write(CFG_ESC_END,      CFG_DATA_W'(c.esc_end));
        reg_write(CFG_ESC_ESC,      CFG_DATA_W'(c.esc_esc));
        reg_write(CFG_SPARE_LO,     $urandom());
        reg_write(CFG_SPARE_HI,     $urandom());
        cfg_we <= 1'b0;
        cur = c;
    endtask

    // Drop valid and wait for every outstanding result. Each transaction
    // gives exactly one result.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaiting != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_phase(t_cfg c, t_gap_mode mode, int quota, bit squeeze);
        int stop_at;
        int cap_now;
        int len;
        int pick;
        load_cfg(c);
        send_idle_pct = (mode == GAPS_SENDER) ? 79 : (mode == GAPS_BOTH) ? 12 : 0;
        stall_pct     = (mode == GAPS_RECEIVER) ? 79 : (mode == GAPS_BOTH) ? 12 : 0;
        if (squeeze) holdoff_requests++;
        stop_at = sent + quota;
        cap_now = (c.capacity > MAX_LEN) ? MAX_PAYLOAD : int'(c.capacity);
        while (sent < stop_at) begin
            // mostly short frames, now and then one past capacity
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cap_now + 2)
                                              : $urandom_range(0, (cap_now < 6) ? cap_now : 6);
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                // well-formed frame, delimiter and escape values favoured in the payload
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 6) == 0)
                        rx_literal($urandom_range(0, 1) ? cur.end_byte : cur.esc_byte);
                    else
                        rx_literal(BYTE_W'($urandom()));
                end
                rx(cur.end_byte);
                // completed frames stay; sometimes clear, read back or probe
                case ($urandom_range(0, 9))
                    0, 1, 2: send(OP_CLEAR, BYTE_W'($urandom()), $urandom(),
                                  ADDR_W'($urandom()));
                    3, 4:    send(OP_READ, BYTE_W'($urandom()), $urandom(),
                                  ADDR_W'($urandom()));
                    5, 6:    idle_probe();
                    default: ;
                endcase
            end else if (pick < 16) begin
                // noise: any operation, any field values
                send(t_op'($urandom_range(0, 3)), BYTE_W'($urandom()), $urandom(),
                     ADDR_W'($urandom()));
            end else if (pick < 19) begin
                // broken frame: raw bytes, then a bad ending
                for (int k = 0; k < len; k++) rx(BYTE_W'($urandom()));
                case ($urandom_range(0, 3))
                    0: begin
                        rx(cur.esc_byte);
                        rx(BYTE_W'($urandom()));
                    end
                    1: begin
                        rx(cur.esc_byte);
                        rx(cur.end_byte);
                    end
                    2: idle_probe();
                    default: begin
                        rx(cur.esc_byte);
                        idle_probe();
                    end
                endcase
            end else begin
                idle_probe();
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= OP_RECV;
        in_ch.data_byte      <= '0;
        in_ch.now_ms         <= '0;
        in_ch.read_index     <= '0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        holdoff_requests     = 0;
        sent                 = 0;
        tick_ms              = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // SLIP defaults, idle check off
        load_cfg('{idle_timeout: 32'd0, capacity: MAX_LEN, end_byte: 8'hC0,
                   esc_byte: 8'hDB, esc_end: 8'hDC, esc_esc: 8'hDD});

        // Fill every payload entry: entry i holds i. END and ESC values go
        // through the escape path. Completes at full length.
        for (int v = 0; v < MAX_PAYLOAD; v++) rx_literal(8'(v));
        rx(cur.end_byte);
        rx(8'h77);              // over capacity -> discard mode
        rx(cur.end_byte);       // reports the discard
        drain();

        // Hand-made sequence with a 1000 ms idle timeout
        load_cfg('{idle_timeout: 32'd1000, capacity: MAX_LEN, end_byte: 8'hC0,
                   esc_byte: 8'hDB, esc_end: 8'hDC, esc_esc: 8'hDD});
        send(OP_RECV, cur.end_byte, 32'd0, 8'h00);     // END on an empty frame is ignored
        send(OP_RECV, 8'h00, 32'd1, 8'hFF);
        send(OP_RECV, 8'hFF, 32'd2, 8'h00);
        send(OP_RECV, cur.esc_byte, 32'd3, ADDR_W'($urandom()));
        send(OP_RECV, cur.esc_end, 32'd4, ADDR_W'($urandom())); // literal END stored
        send(OP_RECV, cur.esc_byte, 32'd5, ADDR_W'($urandom()));
        send(OP_RECV, cur.esc_esc, 32'd6, ADDR_W'($urandom())); // literal ESC stored
        send(OP_RECV, cur.end_byte, 32'd7, ADDR_W'($urandom())); // frame of four complete
        send(OP_READ, BYTE_W'($urandom()), $urandom(), 8'd0);
        send(OP_READ, BYTE_W'($urandom()), $urandom(), 8'd2);
        send(OP_READ, BYTE_W'($urandom()), $urandom(), 8'd255);
        send(OP_RECV, 8'h41, 32'd10, ADDR_W'($urandom()));       // appends to the completed frame
        send(OP_IDLE, BYTE_W'($urandom()), 32'd1009, ADDR_W'($urandom())); // one short of the timeout
        send(OP_IDLE, BYTE_W'($urandom()), 32'd1010, ADDR_W'($urandom())); // timeout reached: cleared
        send(OP_RECV, 8'h42, 32'hFFFF_FFFF, ADDR_W'($urandom()));
        send(OP_IDLE, BYTE_W'($urandom()), 32'h0000_0100,
             ADDR_W'($urandom()));                                 // wrapped gap, too short
        send(OP_IDLE, BYTE_W'($urandom()), 32'h0000_03E7,
             ADDR_W'($urandom()));                                 // wrapped gap of exactly 1000
        send(OP_RECV, cur.esc_byte, 32'd20, ADDR_W'($urandom()));
        send(OP_RECV, cur.end_byte, 32'd21, ADDR_W'($urandom()));  // ESC then END drops the frame
        send(OP_RECV, 8'h01, 32'd22, ADDR_W'($urandom()));
        send(OP_RECV, cur.esc_byte, 32'd23, ADDR_W'($urandom()));
        send(OP_RECV, 8'h33, 32'd24, ADDR_W'($urandom()));         // bad escape code -> discard mode
        send(OP_RECV, 8'h44, 32'd25, ADDR_W'($urandom()));         // swallowed
        send(OP_RECV, cur.end_byte, 32'd26, ADDR_W'($urandom()));  // discard reported
        send(OP_RECV, 8'h10, 32'd27, ADDR_W'($urandom()));
        send(OP_CLEAR, BYTE_W'($urandom()), $urandom(), ADDR_W'($urandom()));
        drain();
        tick_ms = 32'd100;

        // Random phases. Settings cover the extremes of every register and
        // the cases where delimiter codes coincide (test order decides).
        run_phase('{idle_timeout: 32'hFFFF_FFFF, capacity: MAX_LEN, end_byte: 8'hC0,
                    esc_byte: 8'hDB, esc_end: 8'hDC, esc_esc: 8'hDD},
                  GAPS_NONE, 200, 1'b1);
        run_phase('{idle_timeout: 32'd1, capacity: 9'd1, end_byte: 8'h00,
                    esc_byte: 8'hFF, esc_end: 8'h01, esc_esc: 8'hFF},
                  GAPS_SENDER, 200, 1'b0);
        run_phase('{idle_timeout: 32'd50, capacity: 9'd8, end_byte: 8'h7E,
                    esc_byte: 8'h7D, esc_end: 8'h10, esc_esc: 8'h10},
                  GAPS_RECEIVER, 220, 1'b0);
        run_phase('{idle_timeout: 32'd20, capacity: 9'd0, end_byte: 8'hC0,
                    esc_byte: 8'hDB, esc_end: 8'h00, esc_esc: 8'hDD},
                  GAPS_BOTH, 180, 1'b0);
        run_phase('{idle_timeout: 32'd200, capacity: 9'd511, end_byte: 8'hC0,
                    esc_byte: 8'hDB, esc_end: 8'hC0, esc_esc: 8'hDD},
                  GAPS_NONE, 220, 1'b0);
        run_phase('{idle_timeout: 32'd1000, capacity: 9'd16, end_byte: 8'h55,
                    esc_byte: 8'h55, esc_end: 8'h56, esc_esc: 8'h57},
                  GAPS_SENDER, 200, 1'b0);
        run_phase('{idle_timeout: 32'd0, capacity: 9'd255, end_byte: 8'hFF,
                    esc_byte: 8'h00, esc_end: 8'hFF, esc_esc: 8'h00},
                  GAPS_RECEIVER, 220, 1'b0);
        run_phase('{idle_timeout: 32'd300, capacity: 9'd40, end_byte: 8'hC0,
                    esc_byte: 8'hDB, esc_end: 8'hDC, esc_esc: 8'hDD},
                  GAPS_BOTH, 220, 1'b0);

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
